### rtl/core/price_level_order_book_defines.svh
// assertion macros for the order book datapath rtl
`ifndef PRICE_LEVEL_ORDER_BOOK_DEFINES_SVH
`define PRICE_LEVEL_ORDER_BOOK_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PLOB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PLOB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/plob_pkg.sv
package plob_pkg;

    // sizing
    localparam int ORDER_SLOTS = 1024;
    localparam int LEVELS      = 64;
    localparam int PRICE_BITS  = 40;

    localparam int ORD_AW = $clog2(ORDER_SLOTS);
    localparam int IDX_W  = $clog2(LEVELS);
    localparam int DEP_W  = $clog2(LEVELS + 1);
    localparam int SH_W   = 32;
    localparam int TOT_W  = 42;
    localparam int CNT_W  = 11;
    localparam int ORD_W  = 2 + PRICE_BITS + SH_W;

    localparam logic [PRICE_BITS-1:0] PRICE_MASK = {PRICE_BITS{1'b1}};

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_MODIFY = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_QUERY  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic lookup;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic out_free;
    } t_sts;

    // bids rank high first, asks low first
    function automatic logic better(input logic side,
                                    input logic [PRICE_BITS-1:0] a,
                                    input logic [PRICE_BITS-1:0] b);
        return side ? (a < b) : (a > b);
    endfunction

endpackage

### rtl/core/plob_ram.sv
module plob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/plob_ctrl.sv
module plob_ctrl import plob_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (i_sts.clr_done) n_state = S_IDLE;
            S_IDLE:   if (i_in_valid) n_state = S_READ;
            S_READ:   n_state = S_COMMIT;
            S_COMMIT: if (i_sts.out_free) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR:  o_cmd.clear = !i_sts.clr_done;
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_READ:   o_cmd.lookup = 1'b1;
            S_COMMIT: o_cmd.commit = i_sts.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

### rtl/core/plob_dp.sv
`include "price_level_order_book_defines.svh"

module plob_dp import plob_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [1:0]  i_req_type,
    input  logic [9:0]  i_slot_id,
    input  logic        i_side,
    input  logic [39:0] i_price,
    input  logic [31:0] i_shares,
    input  logic [7:0]  i_level,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [1:0]  o_status,
    output logic [39:0] o_level_price,
    output logic [41:0] o_level_size
);

    // latched request
    t_req                  r_req;
    logic [9:0]            r_id;
    logic                  r_side;
    logic [PRICE_BITS-1:0] r_price;
    logic [SH_W-1:0]       r_sh;
    logic [7:0]            r_lvl;

    // stored order and lookup vectors
    logic                  r_olive;
    logic                  r_oside;
    logic [PRICE_BITS-1:0] r_oprice;
    logic [SH_W-1:0]       r_osh;
    logic                  r_ks;
    logic [LEVELS-1:0]     r_match;
    logic [LEVELS-1:0]     r_nb;
    logic [LEVELS-1:0]     r_aa;

    // level cells, one row per side
    logic [PRICE_BITS-1:0] r_pr  [2][LEVELS];
    logic [TOT_W-1:0]      r_tt  [2][LEVELS];
    logic [CNT_W-1:0]      r_oc  [2][LEVELS];
    logic [DEP_W-1:0]      r_dep [2];

    logic [ORD_AW:0]       r_clr_cnt;

    logic                  r_out_valid;
    logic [1:0]            r_status;
    logic [39:0]           r_lp;
    logic [41:0]           r_ls;

    // order store
    logic                  ram_we;
    logic [ORD_AW-1:0]     ram_waddr;
    logic [ORD_W-1:0]      ram_wdata;
    logic [ORD_W-1:0]      ram_rdata;
    logic                  rd_live;
    logic                  rd_side;
    logic [PRICE_BITS-1:0] rd_price;
    logic [SH_W-1:0]       rd_sh;
    logic                  key_side;
    logic [PRICE_BITS-1:0] key_price;
    logic [DEP_W-1:0]      key_dep;

    // commit logic
    logic                  id_ok;
    logic                  any;
    logic [TOT_W-1:0]      sel_tt;
    logic [CNT_W-1:0]      sel_oc;
    logic [CNT_W-1:0]      new_oc;
    logic [DEP_W-1:0]      dep_k;
    logic                  do_ins;
    logic                  do_join;
    logic                  do_adj;
    logic                  do_rem;
    logic                  do_drop;
    logic                  do_dec;
    logic                  wr_c;
    logic [ORD_W-1:0]      wd_c;
    t_status               st_c;
    logic [39:0]           lp_c;
    logic [41:0]           ls_c;
    logic [IDX_W-1:0]      q_idx;
    logic [PRICE_BITS-1:0] n_pr [LEVELS];
    logic [TOT_W-1:0]      n_tt [LEVELS];
    logic [CNT_W-1:0]      n_oc [LEVELS];

    assign rd_live  = ram_rdata[ORD_W-1];
    assign rd_side  = ram_rdata[ORD_W-2];
    assign rd_price = ram_rdata[SH_W +: PRICE_BITS];
    assign rd_sh    = ram_rdata[SH_W-1:0];

    assign ram_we    = i_cmd.clear | (i_cmd.commit & wr_c);
    assign ram_waddr = i_cmd.clear ? r_clr_cnt[ORD_AW-1:0] : ORD_AW'(r_id);
    assign ram_wdata = i_cmd.clear ? '0 : wd_c;

    plob_ram #(
        .WIDTH (ORD_W),
        .DEPTH (ORDER_SLOTS)
    ) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ORD_AW'(i_slot_id)),
        .o_rdata (ram_rdata)
    );

    // clearing sweep over the order store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req   <= t_req'(i_req_type);
            r_id    <= i_slot_id;
            r_side  <= i_side;
            r_price <= PRICE_BITS'(i_price);
            r_sh    <= i_shares;
            r_lvl   <= i_level;
        end
    end

    // key for the level search: new order on add, stored order otherwise
    assign key_side  = (r_req == REQ_ADD) ? r_side : rd_side;
    assign key_price = (r_req == REQ_ADD) ? r_price : rd_price;
    assign key_dep   = r_dep[key_side];

    // parallel compare against every cell of the key side
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_olive  <= rd_live;
            r_oside  <= rd_side;
            r_oprice <= rd_price;
            r_osh    <= rd_sh;
            r_ks     <= key_side;
            for (int i = 0; i < LEVELS; i++) begin
                r_match[i] <= (32'(i) < 32'(key_dep)) &&
                              (r_pr[key_side][i] == key_price);
                r_nb[i]    <= (32'(i) < 32'(key_dep)) &&
                              !better(key_side, key_price, r_pr[key_side][i]);
                r_aa[i]    <= !better(key_side, r_pr[key_side][i], key_price);
            end
        end
    end

    // matched level contents
    always_comb begin
        sel_tt = '0;
        sel_oc = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (r_match[i]) begin
                sel_tt = sel_tt | r_tt[r_ks][i];
                sel_oc = sel_oc | r_oc[r_ks][i];
            end
        end
    end

    assign any    = |r_match;
    assign dep_k  = r_dep[r_ks];
    assign new_oc = (sel_oc != '0) ? (sel_oc - CNT_W'(1)) : '0;
    assign id_ok  = ({22'd0, r_id} < 32'(ORDER_SLOTS));
    assign q_idx  = IDX_W'(r_lvl - 8'd1);
    assign do_dec  = do_rem && any && (new_oc != '0);
    assign do_drop = do_rem && any && (new_oc == '0);

    // request decode and result
    always_comb begin
        st_c    = ST_NONE;
        lp_c    = '0;
        ls_c    = '0;
        do_ins  = 1'b0;
        do_join = 1'b0;
        do_adj  = 1'b0;
        do_rem  = 1'b0;
        wr_c    = 1'b0;
        wd_c    = {r_olive, r_oside, r_oprice, r_osh};
        unique case (r_req)
            REQ_QUERY: begin
                if (r_lvl != 8'd0 && 32'(r_lvl) <= 32'(r_dep[r_side])) begin
                    st_c = ST_OK;
                    lp_c = 40'(r_pr[r_side][q_idx]);
                    ls_c = r_tt[r_side][q_idx];
                end else begin
                    lp_c = r_side ? 40'(PRICE_MASK) : '0;
                end
            end
            REQ_ADD: begin
                if (id_ok) begin
                    if (r_sh == '0) begin
                        st_c = ST_NONE;
                    end else if (r_olive) begin
                        st_c = ST_DUP;
                    end else if (!any && 32'(dep_k) >= 32'(LEVELS)) begin
                        st_c = ST_FULL;
                    end else begin
                        st_c    = ST_OK;
                        do_ins  = !any;
                        do_join = any;
                        wr_c    = 1'b1;
                        wd_c    = {1'b1, r_side, r_price, r_sh};
                    end
                end
            end
            REQ_MODIFY: begin
                if (id_ok && r_olive) begin
                    st_c = ST_OK;
                    wr_c = 1'b1;
                    if (r_sh == '0) begin
                        do_rem = 1'b1;
                        wd_c   = {1'b0, r_oside, r_oprice, r_osh};
                    end else begin
                        do_adj = any;
                        wd_c   = {1'b1, r_oside, r_oprice, r_sh};
                    end
                end
            end
            REQ_REMOVE: begin
                if (id_ok && r_olive) begin
                    st_c   = ST_OK;
                    do_rem = 1'b1;
                    wr_c   = 1'b1;
                    wd_c   = {1'b0, r_oside, r_oprice, r_osh};
                end
            end
            default: st_c = ST_NONE;
        endcase
    end

    // next cell contents: insert shifts down, drop shifts up
    always_comb begin
        int pi;
        int ni;
        logic prev_nb;
        for (int i = 0; i < LEVELS; i++) begin
            pi      = (i == 0) ? 0 : i - 1;
            ni      = (i == LEVELS - 1) ? i : i + 1;
            prev_nb = (i == 0) ? 1'b1 : r_nb[pi];
            n_pr[i] = r_pr[r_ks][i];
            n_tt[i] = r_tt[r_ks][i];
            n_oc[i] = r_oc[r_ks][i];
            if (do_ins && !r_nb[i]) begin
                if (prev_nb) begin
                    n_pr[i] = r_price;
                    n_tt[i] = TOT_W'(r_sh);
                    n_oc[i] = CNT_W'(1);
                end else begin
                    n_pr[i] = r_pr[r_ks][pi];
                    n_tt[i] = r_tt[r_ks][pi];
                    n_oc[i] = r_oc[r_ks][pi];
                end
            end else if (do_join && r_match[i]) begin
                n_tt[i] = r_tt[r_ks][i] + TOT_W'(r_sh);
                n_oc[i] = r_oc[r_ks][i] + CNT_W'(1);
            end else if (do_adj && r_match[i]) begin
                n_tt[i] = r_tt[r_ks][i] - TOT_W'(r_osh) + TOT_W'(r_sh);
            end else if (do_dec && r_match[i]) begin
                n_tt[i] = r_tt[r_ks][i] - TOT_W'(r_osh);
                n_oc[i] = new_oc;
            end else if (do_drop && r_aa[i]) begin
                n_pr[i] = r_pr[r_ks][ni];
                n_tt[i] = r_tt[r_ks][ni];
                n_oc[i] = r_oc[r_ks][ni];
            end
        end
    end

    // cell update
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_pr[r_ks][i] <= n_pr[i];
                r_tt[r_ks][i] <= n_tt[i];
                r_oc[r_ks][i] <= n_oc[i];
            end
        end
    end

    // level counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dep[0] <= '0;
            r_dep[1] <= '0;
        end else if (i_cmd.commit) begin
            if (do_ins) begin
                r_dep[r_ks] <= dep_k + 1'b1;
            end else if (do_drop && dep_k != '0) begin
                r_dep[r_ks] <= dep_k - 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= st_c;
            r_lp     <= lp_c;
            r_ls     <= ls_c;
        end
    end

    assign o_sts.clr_done = r_clr_cnt[ORD_AW];
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_level_price  = r_lp;
    assign o_level_size   = r_ls;

    `PLOB_ASSERT_IMP(a_bid_depth, 1'b1, 32'(r_dep[0]) <= 32'(LEVELS), "bid depth overflow")
    `PLOB_ASSERT_IMP(a_ask_depth, 1'b1, 32'(r_dep[1]) <= 32'(LEVELS), "ask depth overflow")
    `PLOB_ASSERT_IMP(a_one_level, i_cmd.commit, $onehot0(r_match), "price on two levels")
    `PLOB_ASSERT_NXT(a_result_out, i_cmd.commit, r_out_valid, "result not presented")

endmodule

### rtl/core/price_level_order_book.sv
// channel   dir  tdata fields (low bit up)                      tuser
// s_axis    in   slot id, side, price, shares, level, pad to 96  req_type
// m_axis    out  status level_price level_size, pad to 88       -
//
// each item goes through capture and order store read, a parallel
// compare over all level cells of one side, then a commit that
// shifts, adjusts the cells and writes the order store.
// after reset an order store clearing pass writes all ORDER_SLOTS
// (1024) entries before s_axis_tready rises.
// the result sits in an output register; the commit waits while it is
// still unread, otherwise the next item is taken right after.
module price_level_order_book import plob_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // slot id, side, price, shares, level
    input  logic [1:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // status, level_price, level_size
);

    t_cmd        cmd;
    t_sts        sts;
    logic [1:0]  status;
    logic [39:0] level_price;
    logic [41:0] level_size;

    // sequencer
    plob_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // order store, level cells and result register
    plob_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (s_axis_tuser),
        .i_slot_id     (s_axis_tdata[9:0]),
        .i_side        (s_axis_tdata[10]),
        .i_price       (s_axis_tdata[50:11]),
        .i_shares      (s_axis_tdata[82:51]),
        .i_level       (s_axis_tdata[90:83]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (status),
        .o_level_price (level_price),
        .o_level_size  (level_size)
    );

    assign m_axis_tdata = {4'd0, level_size, level_price, status};

endmodule
